@@ design/ccsec_pkg.sv @@
// shared constants, types and codes for the cyclic code single error corrector
// no dependencies
package ccsec_pkg;

  localparam int DATA_W      = 64;
  localparam int SYN_W       = 63;
  localparam int POS_W       = 6;
  localparam int LEN_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int MAX_LEN_DEF = 64;

  localparam logic [LEN_W-1:0]  CODE_LENGTH_RST = 7'd7;
  localparam logic [DATA_W-1:0] GEN_POLY_RST    = 64'd11;

  localparam logic [CFG_IDX_W-1:0] REG_CODE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GEN_POLY    = 2'd1;

  typedef enum logic [1:0] {
    ST_CLEAN,
    ST_CORRECTED,
    ST_UNCORRECTABLE,
    ST_INVALID
  } status_t;

  typedef enum logic [1:0] {
    SEQ_DEG,
    SEQ_DIV,
    SEQ_DONE
  } seq_state_t;

  typedef struct packed {
    logic done;
    logic ok;
  } derive_stat_t;

endpackage

@@ design/cyclic_code_single_error_corrector_unit.sv @@
// single error correcting decoder for a binary cyclic code of configurable length
// result registered through a four register pipeline: mask, syndrome, column match, correct;
// one word per cycle while out_ready does not stall the pipeline
// after reset or any configuration write the check polynomial is derived one bit
// per cycle, with in_ready low; reset gives n = 7, g = 11
// depends on ccsec_pkg and ccsec_derive
module cyclic_code_single_error_corrector_unit #(
  parameter int MAX_LEN = ccsec_pkg::MAX_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ccsec_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ccsec_pkg::DATA_W-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ccsec_pkg::DATA_W-1:0]        received_word,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ccsec_pkg::DATA_W-1:0]        corrected_word,
  output logic [ccsec_pkg::SYN_W-1:0]         syndrome_bits,
  output logic [ccsec_pkg::POS_W-1:0]         error_position,
  output logic [1:0]                          decode_status
);

  localparam int W  = MAX_LEN;
  localparam int SW = MAX_LEN - 1;
  localparam int PW = $clog2(MAX_LEN);
  localparam int LW = ccsec_pkg::LEN_W;
  localparam int DW = ccsec_pkg::DATA_W;

  logic [LW-1:0] code_len;
  logic [DW-1:0] gen_poly;
  logic          cfg_xfer;

  ccsec_pkg::derive_stat_t stat;
  logic [W-1:0]  h;
  logic [SW-1:0] row_mask;
  logic [W-1:0]  word_mask;

  logic adv1, adv2, adv3, adv4;
  logic v1, v2, v3;
  logic [W-1:0]  w1, w2, w3;
  logic [SW-1:0] syn2, syn3;
  logic [W-1:0]  hit3;
  logic          zero3;

  logic [SW-1:0]          syn_c;
  logic [W-1:0][SW-1:0]   cols;
  logic [W-1:0]           hit_c;
  logic [W-1:0]           low;
  logic [PW-1:0]          pos_c;

  logic                   ov;
  logic [W-1:0]           cw;
  logic [SW-1:0]          syn_o;
  logic [PW-1:0]          pos_o;
  ccsec_pkg::status_t     status_o;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_len <= ccsec_pkg::CODE_LENGTH_RST;
      gen_poly <= ccsec_pkg::GEN_POLY_RST;
    end else if (cfg_xfer) begin
      if (cfg_index == ccsec_pkg::REG_CODE_LENGTH) code_len <= cfg_data[LW-1:0];
      if (cfg_index == ccsec_pkg::REG_GEN_POLY)    gen_poly <= cfg_data;
    end
  end

  ccsec_derive #(
    .MAX_LEN(MAX_LEN)
  ) u_derive (
    .clk           (clk),
    .rst           (rst),
    .restart       (cfg_xfer),
    .code_length   (code_len),
    .generator_poly(gen_poly),
    .stat          (stat),
    .check_poly    (h),
    .row_mask      (row_mask),
    .word_mask     (word_mask)
  );

  // stall chain
  assign adv4     = !ov || out_ready;
  assign adv3     = !v3 || adv4;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1 && stat.done;

  // syndrome
  always_comb begin
    for (int r = 0; r < SW; r++) begin
      syn_c[r] = row_mask[r] & (^(w1 & (h << r)));
    end
  end

  // parity check columns and match
  always_comb begin
    for (int j = 0; j < W; j++) begin
      for (int r = 0; r < SW; r++) begin
        if (r <= j) cols[j][r] = h[j-r] & row_mask[r];
        else        cols[j][r] = 1'b0;
      end
      hit_c[j] = word_mask[j] && (cols[j] == syn2);
    end
  end

  // lowest matching column
  always_comb begin
    low   = hit3 & (~hit3 + 1'b1);
    pos_c = '0;
    for (int j = 0; j < W; j++) begin
      if (low[j]) pos_c = pos_c | PW'(j);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid && in_ready;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) ov <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) w1 <= received_word[W-1:0] & word_mask;
    if (adv2) begin
      w2   <= w1;
      syn2 <= syn_c;
    end
    if (adv3) begin
      w3    <= w2;
      syn3  <= syn2;
      hit3  <= hit_c;
      zero3 <= (syn2 == '0);
    end
    if (adv4) begin
      if (!stat.ok) begin
        cw       <= '0;
        syn_o    <= '0;
        pos_o    <= '0;
        status_o <= ccsec_pkg::ST_INVALID;
      end else if (zero3) begin
        cw       <= w3;
        syn_o    <= syn3;
        pos_o    <= '0;
        status_o <= ccsec_pkg::ST_CLEAN;
      end else if (|hit3) begin
        cw       <= w3 ^ low;
        syn_o    <= syn3;
        pos_o    <= pos_c;
        status_o <= ccsec_pkg::ST_CORRECTED;
      end else begin
        cw       <= w3;
        syn_o    <= syn3;
        pos_o    <= '0;
        status_o <= ccsec_pkg::ST_UNCORRECTABLE;
      end
    end
  end

  assign out_valid      = ov;
  assign corrected_word = DW'(cw);
  assign syndrome_bits  = ccsec_pkg::SYN_W'(syn_o);
  assign error_position = ccsec_pkg::POS_W'(pos_o);
  assign decode_status  = status_o;

endmodule

@@ design/ccsec_derive.sv @@
// derives degree, check polynomial and masks from the code configuration
// one bit per cycle; depends on ccsec_pkg
module ccsec_derive #(
  parameter int MAX_LEN = ccsec_pkg::MAX_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             restart,
  input  logic [ccsec_pkg::LEN_W-1:0]      code_length,
  input  logic [ccsec_pkg::DATA_W-1:0]     generator_poly,
  output ccsec_pkg::derive_stat_t          stat,
  output logic [MAX_LEN-1:0]               check_poly,
  output logic [MAX_LEN-2:0]               row_mask,
  output logic [MAX_LEN-1:0]               word_mask
);

  localparam int W = MAX_LEN;
  localparam int DW = ccsec_pkg::DATA_W;
  localparam int LW = ccsec_pkg::LEN_W;
  localparam int PW = ccsec_pkg::POS_W;

  ccsec_pkg::seq_state_t state, state_next;
  logic [LW-1:0] cnt, cnt_next;
  logic [PW-1:0] deg, deg_next;
  logic          seen, seen_next;
  logic [DW-1:0] rem, rem_next;
  logic [W-1:0]  quo, quo_next;
  logic          ok;
  logic [DW-1:0] rem_s;
  logic          in_bit;

  always_comb begin
    state_next = state;
    unique case (state)
      ccsec_pkg::SEQ_DEG: begin
        if (cnt == LW'(DW - 1)) state_next = ccsec_pkg::SEQ_DIV;
      end
      ccsec_pkg::SEQ_DIV: begin
        if (cnt == '0) state_next = ccsec_pkg::SEQ_DONE;
      end
      ccsec_pkg::SEQ_DONE: begin
        state_next = ccsec_pkg::SEQ_DONE;
      end
      default: begin
        state_next = ccsec_pkg::SEQ_DEG;
      end
    endcase
    if (restart) state_next = ccsec_pkg::SEQ_DEG;
  end

  always_comb begin
    cnt_next  = cnt;
    deg_next  = deg;
    seen_next = seen;
    rem_next  = rem;
    quo_next  = quo;
    in_bit    = (cnt == code_length) || (cnt == '0);
    rem_s     = {rem[DW-2:0], in_bit};
    unique case (state)
      ccsec_pkg::SEQ_DEG: begin
        cnt_next = cnt + 1'b1;
        if (generator_poly[cnt[PW-1:0]]) begin
          deg_next  = cnt[PW-1:0];
          seen_next = 1'b1;
        end
        if (cnt == LW'(DW - 1)) begin
          cnt_next = code_length;
          rem_next = '0;
          quo_next = '0;
        end
      end
      ccsec_pkg::SEQ_DIV: begin
        cnt_next = cnt - 1'b1;
        if (rem_s[deg]) begin
          rem_next = rem_s ^ generator_poly;
          for (int j = 0; j < W; j++) begin
            if (cnt == LW'(j)) quo_next[j] = 1'b1;
          end
        end else begin
          rem_next = rem_s;
        end
      end
      ccsec_pkg::SEQ_DONE: begin
        cnt_next = cnt;
      end
      default: begin
        cnt_next = cnt;
      end
    endcase
    if (restart) begin
      cnt_next  = '0;
      deg_next  = '0;
      seen_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ccsec_pkg::SEQ_DEG;
      cnt   <= '0;
      deg   <= '0;
      seen  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      deg   <= deg_next;
      seen  <= seen_next;
    end
  end

  always_ff @(posedge clk) begin
    rem <= rem_next;
    quo <= quo_next;
    ok  <= (code_length >= LW'(2)) && (code_length <= LW'(MAX_LEN)) && seen
           && ({1'b0, deg} < code_length) && (rem == '0);
    for (int r = 0; r < W - 1; r++) begin
      row_mask[r] <= (deg > PW'(r));
    end
    for (int j = 0; j < W; j++) begin
      word_mask[j] <= (code_length > LW'(j));
    end
  end

  assign check_poly = quo;
  assign stat.done  = (state == ccsec_pkg::SEQ_DONE);
  assign stat.ok    = ok;

endmodule
